// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// Checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SHFD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("shfd assertion failed");
`define SHFD_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("shfd assertion failed");
`else
`define SHFD_ASSERT(lbl, clk, rst, prop)
`define SHFD_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// File: hw/rtl/shfd_pkg.sv
// Types and constants of the sync-header frame deframer.
// No dependencies.
package shfd_pkg;

  localparam int HDR_BYTES = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_SYNC  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_SYNC = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VERSION     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SWITCH_A    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SWITCH_B    = 3'd4;

  localparam logic [7:0] RST_FIRST_SYNC  = 8'hA5;
  localparam logic [7:0] RST_SECOND_SYNC = 8'h5A;
  localparam logic [7:0] RST_VERSION     = 8'h02;
  localparam logic [7:0] RST_SWITCH_A    = 8'h04;
  localparam logic [7:0] RST_SWITCH_B    = 8'h05;

  typedef struct packed {
    logic [7:0] first_sync;
    logic [7:0] second_sync;
    logic [7:0] version;
    logic [7:0] switch_a;
    logic [7:0] switch_b;
  } cfg_regs_t;

  typedef struct packed {
    logic       go;
    logic       ok;
    logic [7:0] sw_byte;
  } start_t;

endpackage

// File: hw/rtl/shfd_rx_if.sv
// Received byte channel of the deframer.
// No dependencies.
interface shfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// File: hw/rtl/shfd_res_if.sv
// Result channel of the deframer.
// No dependencies.
interface shfd_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [5:0] byte_index;
  logic       last_of_frame;
  logic       frame_dropped;

  modport source (output valid, output out_byte, output byte_index,
                  output last_of_frame, output frame_dropped, input ready);
  modport sink (input valid, input out_byte, input byte_index,
                input last_of_frame, input frame_dropped, output ready);
endinterface

// File: hw/rtl/shfd_cfg_if.sv
// Configuration write channel of the deframer.
// Depends on shfd_pkg for the register index width.
interface shfd_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [shfd_pkg::CFG_IDX_W-1:0] index;
  logic [7:0]                   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/shfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module shfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 14
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/shfd_hunt.sv
// Header hunt and body collection: writes body bytes to the frame RAM.
// Depends on shfd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module shfd_hunt #(
  parameter int FRAME_BYTES = 17
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           rx_byte,
  input  shfd_pkg::cfg_regs_t  cfg,
  output logic                 we,
  output logic [((FRAME_BYTES - shfd_pkg::HDR_BYTES > 1) ?
                 $clog2(FRAME_BYTES - shfd_pkg::HDR_BYTES) : 1)-1:0] waddr,
  output logic [7:0]           wdata,
  output logic [2:0][7:0]      hdr,
  output shfd_pkg::start_t     start
);
  import shfd_pkg::*;

  localparam int BD  = FRAME_BYTES - HDR_BYTES;
  localparam int BAW = (BD > 1) ? $clog2(BD) : 1;
  localparam int IW  = $clog2(FRAME_BYTES);
  localparam logic [IW-1:0] LAST  = IW'(FRAME_BYTES - 1);
  localparam logic [IW-1:0] FIRST = IW'(HDR_BYTES);

  typedef enum logic [3:0] {
    PH_SYNC0 = 4'b0001,
    PH_SYNC1 = 4'b0010,
    PH_VER   = 4'b0100,
    PH_BODY  = 4'b1000
  } phase_t;

  phase_t        phase, phase_next;
  logic [IW-1:0] wpos, wpos_next;
  logic [IW-1:0] wpos_off;
  logic          hdr_load;
  logic          go;

  always_comb begin
    phase_next = phase;
    wpos_next  = wpos;
    we         = 1'b0;
    hdr_load   = 1'b0;
    go         = 1'b0;
    if (accept) begin
      case (phase)
        PH_SYNC0: begin
          if (rx_byte == cfg.first_sync) phase_next = PH_SYNC1;
        end
        PH_SYNC1: begin
          if (rx_byte == cfg.second_sync) phase_next = PH_VER;
          else if (rx_byte != cfg.first_sync) phase_next = PH_SYNC0;
        end
        PH_VER: begin
          if (rx_byte == cfg.version) begin
            hdr_load   = 1'b1;
            wpos_next  = FIRST;
            phase_next = PH_BODY;
          end else if (rx_byte == cfg.first_sync) begin
            phase_next = PH_SYNC1;
          end else begin
            phase_next = PH_SYNC0;
          end
        end
        PH_BODY: begin
          we = 1'b1;
          if (wpos != LAST) begin
            wpos_next = wpos + IW'(1);
          end else begin
            go         = 1'b1;
            wpos_next  = '0;
            phase_next = PH_SYNC0;
          end
        end
        default: begin
          phase_next = PH_SYNC0;
          wpos_next  = '0;
        end
      endcase
    end
  end

  assign wpos_off      = wpos - FIRST;
  assign waddr         = wpos_off[BAW-1:0];
  assign wdata         = rx_byte;
  assign start.go      = go;
  assign start.ok      = (rx_byte == cfg.switch_a) || (rx_byte == cfg.switch_b);
  assign start.sw_byte = rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SYNC0;
      wpos  <= '0;
    end else begin
      phase <= phase_next;
      wpos  <= wpos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_load) begin
      hdr[0] <= cfg.first_sync;
      hdr[1] <= cfg.second_sync;
      hdr[2] <= rx_byte;
    end
  end

  `SHFD_ASSERT(a_body_pos, clk, rst, phase == PH_BODY |-> wpos >= FIRST && wpos <= LAST)
  `SHFD_ASSERT(a_go_rehunt, clk, rst, go |=> phase == PH_SYNC0 && wpos == '0)
  `SHFD_ASSERT(a_ver_enter, clk, rst, hdr_load |=> phase == PH_BODY && wpos == FIRST)
  `SHFD_ASSERT_NR(a_go_beat, clk, start.go |-> accept && we)

endmodule

// File: hw/rtl/shfd_replay.sv
// Frame replay: reads the frame RAM and drives the result channel.
// Depends on shfd_pkg, shfd_res_if and assert_macros.svh.
`include "assert_macros.svh"
module shfd_replay #(
  parameter int FRAME_BYTES = 17
) (
  input  logic                 clk,
  input  logic                 rst,
  input  shfd_pkg::start_t     start,
  input  logic [2:0][7:0]      hdr,
  input  logic [7:0]           rdata,
  output logic                 re,
  output logic [((FRAME_BYTES - shfd_pkg::HDR_BYTES > 1) ?
                 $clog2(FRAME_BYTES - shfd_pkg::HDR_BYTES) : 1)-1:0] raddr,
  output logic                 idle,
  shfd_res_if.source           res
);
  import shfd_pkg::*;

  localparam int BD  = FRAME_BYTES - HDR_BYTES;
  localparam int BAW = (BD > 1) ? $clog2(BD) : 1;
  localparam int IW  = $clog2(FRAME_BYTES);
  localparam logic [IW-1:0] LAST  = IW'(FRAME_BYTES - 1);
  localparam logic [IW-1:0] FIRST = IW'(HDR_BYTES);

  logic          busy;
  logic          ov;
  logic          advance;
  logic          odrop;
  logic [7:0]    drop_byte;
  logic [IW-1:0] oidx;
  logic [IW-1:0] nidx;
  logic [IW-1:0] nidx_off;

  assign advance  = !ov || res.ready;
  assign idle     = !busy && !ov;
  assign re       = busy && advance && (nidx >= FIRST);
  assign nidx_off = nidx - FIRST;
  assign raddr    = nidx_off[BAW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ov   <= 1'b0;
    end else begin
      if (start.go && start.ok) busy <= 1'b1;
      else if (busy && advance && nidx == LAST) busy <= 1'b0;
      if (start.go && !start.ok) ov <= 1'b1;
      else if (advance) ov <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start.go) begin
      nidx      <= '0;
      odrop     <= !start.ok;
      drop_byte <= start.sw_byte;
      oidx      <= LAST;
    end else if (busy && advance) begin
      oidx  <= nidx;
      nidx  <= nidx + IW'(1);
      odrop <= 1'b0;
    end
  end

  always_comb begin
    if (odrop) res.out_byte = drop_byte;
    else if (oidx < FIRST) res.out_byte = hdr[oidx[1:0]];
    else res.out_byte = rdata;
  end

  assign res.valid         = ov;
  assign res.byte_index    = 6'(oidx);
  assign res.last_of_frame = (oidx == LAST);
  assign res.frame_dropped = odrop;

  `SHFD_ASSERT(a_go_idle, clk, rst, start.go |-> !busy && !ov)
  `SHFD_ASSERT(a_read_beat, clk, rst, re |=> ov && !odrop && oidx >= FIRST)
  `SHFD_ASSERT(a_run_end, clk, rst, busy && advance && nidx == LAST |=> !busy && ov && oidx == LAST)

endmodule

// File: hw/rtl/sync_header_frame_deframer.sv
// Sync-header fixed-length frame deframer, top level.
// Depends on shfd_pkg, the channel interfaces, shfd_ram, shfd_hunt and shfd_replay.
//
// Channels: rx carries one received byte per beat; res carries result beats
// (out_byte, byte_index, last_of_frame, frame_dropped); cfg writes one of five
// header/switch registers per beat and is always ready.
// Header and body bytes are taken one per cycle. The bytes after the header
// go into a frame RAM of FRAME_BYTES-3 entries; the header is held in flops.
// When the final (switch) byte is taken, rx.ready drops. A good switch byte
// starts a replay of FRAME_BYTES beats, the first one presented once busy and
// then ov have been set, then one beat per cycle while res.ready is high,
// paced by the RAM read port. A bad switch byte gives one drop beat in the
// cycle after it. rx.ready returns once the last result beat has been taken.
// When res.ready is low the presented beat holds and the replay waits.
// Reset returns to the first-sync hunt and loads the default registers; the
// frame RAM is not cleared and needs no clearing pass.
module sync_header_frame_deframer #(
  parameter int FRAME_BYTES = 17
) (
  input  logic        clk,
  input  logic        rst,
  shfd_rx_if.sink     rx,
  shfd_res_if.source  res,
  shfd_cfg_if.sink    cfg
);
  import shfd_pkg::*;

  localparam int BD  = FRAME_BYTES - HDR_BYTES;
  localparam int BAW = (BD > 1) ? $clog2(BD) : 1;

  cfg_regs_t       regs;
  start_t          start;
  logic            accept;
  logic            idle;
  logic            we;
  logic [BAW-1:0]  waddr;
  logic [7:0]      wdata;
  logic            re;
  logic [BAW-1:0]  raddr;
  logic [7:0]      rdata;
  logic [2:0][7:0] hdr;

  assign cfg.ready = 1'b1;
  assign rx.ready  = idle;
  assign accept    = rx.valid && rx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.first_sync  <= RST_FIRST_SYNC;
      regs.second_sync <= RST_SECOND_SYNC;
      regs.version     <= RST_VERSION;
      regs.switch_a    <= RST_SWITCH_A;
      regs.switch_b    <= RST_SWITCH_B;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_FIRST_SYNC:  regs.first_sync  <= cfg.data;
        REG_SECOND_SYNC: regs.second_sync <= cfg.data;
        REG_VERSION:     regs.version     <= cfg.data;
        REG_SWITCH_A:    regs.switch_a    <= cfg.data;
        REG_SWITCH_B:    regs.switch_b    <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  shfd_hunt #(.FRAME_BYTES(FRAME_BYTES)) u_hunt (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx.rx_byte),
    .cfg     (regs),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .hdr     (hdr),
    .start   (start)
  );

  shfd_ram #(.WIDTH(8), .DEPTH(BD)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  shfd_replay #(.FRAME_BYTES(FRAME_BYTES)) u_replay (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .hdr   (hdr),
    .rdata (rdata),
    .re    (re),
    .raddr (raddr),
    .idle  (idle),
    .res   (res)
  );

endmodule
